>>> rtl/rmq_pkg.sv
package rmq_pkg;

    localparam int FUNC_W   = 2;
    localparam int POS_W    = 11;
    localparam int STATUS_W = 2;

    localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_APPEND = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_QUERY  = 2'd2;

    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

endpackage

>>> rtl/rmq_if.sv
interface rmq_req_if #(
    parameter int VALUE_BITS = 32
);
    logic                             valid;
    logic                             ready;
    logic [rmq_pkg::FUNC_W-1:0]       func;
    logic signed [VALUE_BITS-1:0]     value;
    logic [rmq_pkg::POS_W-1:0]        range_begin;
    logic [rmq_pkg::POS_W-1:0]        range_end;

    modport source (output valid, output func, output value, output range_begin,
                    output range_end, input ready);
    modport sink (input valid, input func, input value, input range_begin,
                  input range_end, output ready);
endinterface

interface rmq_rsp_if #(
    parameter int VALUE_BITS = 32
);
    logic                             valid;
    logic                             ready;
    logic signed [VALUE_BITS-1:0]     range_min;
    logic signed [VALUE_BITS-1:0]     range_max;
    logic [rmq_pkg::STATUS_W-1:0]     status;

    modport source (output valid, output range_min, output range_max, output status,
                    input ready);
    modport sink (input valid, input range_min, input range_max, input status,
                  output ready);
endinterface

>>> rtl/rmq_minmax.sv
module rmq_minmax #(
    parameter int VALUE_BITS = 32
) (
    input  logic signed [VALUE_BITS-1:0] i_a_min,
    input  logic signed [VALUE_BITS-1:0] i_a_max,
    input  logic signed [VALUE_BITS-1:0] i_b_min,
    input  logic signed [VALUE_BITS-1:0] i_b_max,
    output logic signed [VALUE_BITS-1:0] o_min,
    output logic signed [VALUE_BITS-1:0] o_max
);

    assign o_min = (i_a_min < i_b_min) ? i_a_min : i_b_min;
    assign o_max = (i_a_max > i_b_max) ? i_a_max : i_b_max;

endmodule

>>> rtl/rmq_table.sv
module rmq_table #(
    parameter int DEPTH  = 2,
    parameter int ADDR_W = 1,
    parameter int DATA_W = 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

>>> rtl/range_min_max_query.sv
// Sparse-table range minimum and maximum engine. One request is worked on at a
// time, and a finished response waits in an output register so that the next
// request can be taken meanwhile. Clear, unused codes, rejected queries and
// appends to a full store are answered from the dispatch state; valid queries
// need two reads of the single table read port and one pass through the shared
// min/max unit. An append at 0-based position p builds table levels 1 to
// floor(log2(p + 1)) in turn: the shared min/max unit builds one table level per
// cycle from one read per level. A finished request waits while the previous
// response still sits unread. The tables are not cleared after reset; every
// window that a valid query reads was written by an append since the last clear.
module range_min_max_query #(
    parameter int MAX_ITEMS  = 1024,
    parameter int VALUE_BITS = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    rmq_req_if.sink    i_req,
    rmq_rsp_if.source  o_rsp
);

    localparam int CNT_W  = $clog2(MAX_ITEMS + 1);
    localparam int IDX_W  = $clog2(MAX_ITEMS);
    localparam int LEVELS = $clog2(MAX_ITEMS + 1);
    localparam int LV_W   = $clog2(LEVELS);
    localparam int LVC_W  = $clog2(LEVELS + 1);
    localparam int DEPTH  = LEVELS * MAX_ITEMS;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CMP_W  = (CNT_W > rmq_pkg::POS_W) ? CNT_W : rmq_pkg::POS_W;
    localparam int LG_W   = $clog2(CMP_W);

    typedef enum logic [5:0] {
        ST_IDLE     = 6'b000001,
        ST_DISPATCH = 6'b000010,
        ST_APPEND   = 6'b000100,
        ST_QHI      = 6'b001000,
        ST_QCOMB    = 6'b010000,
        ST_DONE     = 6'b100000
    } t_state;

    t_state                           r_state;
    logic [CNT_W-1:0]                 r_count;
    logic [rmq_pkg::FUNC_W-1:0]       r_func;
    logic signed [VALUE_BITS-1:0]     r_value;
    logic [rmq_pkg::POS_W-1:0]        r_begin;
    logic [rmq_pkg::POS_W-1:0]        r_end;
    logic [LVC_W-1:0]                 r_lv;
    logic                             r_rd_vld;
    logic [LV_W-1:0]                  r_rd_lv;
    logic [IDX_W-1:0]                 r_rd_j;
    logic [LV_W-1:0]                  r_q_lv;
    logic signed [VALUE_BITS-1:0]     r_acc_min;
    logic signed [VALUE_BITS-1:0]     r_acc_max;
    logic signed [VALUE_BITS-1:0]     r_res_min;
    logic signed [VALUE_BITS-1:0]     r_res_max;
    logic [rmq_pkg::STATUS_W-1:0]     r_res_status;
    logic                             r_out_vld;
    logic signed [VALUE_BITS-1:0]     r_out_min;
    logic signed [VALUE_BITS-1:0]     r_out_max;
    logic [rmq_pkg::STATUS_W-1:0]     r_out_status;

    logic [CMP_W-1:0]                 ext_b;
    logic [CMP_W-1:0]                 ext_e;
    logic [CMP_W-1:0]                 ext_cnt;
    logic                             q_bad;
    logic [CMP_W-1:0]                 q_len;
    logic [LG_W-1:0]                  q_lg;
    logic [LV_W-1:0]                  q_lv;
    logic [CMP_W-1:0]                 q_lo_ext;
    logic [CMP_W-1:0]                 q_hi_ext;
    logic [CNT_W-1:0]                 ap_pos1;
    logic [CNT_W-1:0]                 ap_span;
    logic [CNT_W-1:0]                 ap_j_ext;
    logic                             ap_issue;
    logic                             ap_done;
    logic [LVC_W-1:0]                 ap_rd_lvc;

    logic                             mem_we;
    logic [ADDR_W-1:0]                mem_waddr;
    logic [2*VALUE_BITS-1:0]          mem_wdata;
    logic [ADDR_W-1:0]                mem_raddr;
    logic [2*VALUE_BITS-1:0]          mem_rdata;
    logic signed [VALUE_BITS-1:0]     rd_min;
    logic signed [VALUE_BITS-1:0]     rd_max;
    logic signed [VALUE_BITS-1:0]     u_min;
    logic signed [VALUE_BITS-1:0]     u_max;

    function automatic logic [ADDR_W-1:0] tbl_addr(input logic [LV_W-1:0] lvl,
                                                   input logic [IDX_W-1:0] idx);
        tbl_addr = ADDR_W'(lvl) * ADDR_W'(MAX_ITEMS) + ADDR_W'(idx);
    endfunction

    assign rd_min = mem_rdata[VALUE_BITS-1:0];
    assign rd_max = mem_rdata[2*VALUE_BITS-1:VALUE_BITS];

    always_comb begin
        ext_b    = CMP_W'(r_begin);
        ext_e    = CMP_W'(r_end);
        ext_cnt  = CMP_W'(r_count);
        q_bad    = (ext_b == '0) || (ext_b > ext_e) || (ext_e > ext_cnt);
        q_len    = ext_e - ext_b + CMP_W'(1);
        q_lg     = '0;
        for (int k = 0; k < CMP_W; k++) begin
            if (q_len[k]) begin
                q_lg = LG_W'(k);
            end
        end
        q_lv     = q_lg[LV_W-1:0];
        q_lo_ext = ext_b - CMP_W'(1);
        q_hi_ext = ext_e - (CMP_W'(1) << r_q_lv);

        ap_pos1   = r_count + CNT_W'(1);
        ap_span   = CNT_W'(1) << r_lv;
        ap_j_ext  = ap_pos1 - ap_span;
        ap_rd_lvc = r_lv - LVC_W'(1);
        ap_issue  = (r_state == ST_APPEND) && (r_lv < LVC_W'(LEVELS)) &&
                    (ap_pos1 >= ap_span);
        ap_done   = !ap_issue;
    end

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = '0;
        mem_wdata = {u_max, u_min};
        mem_raddr = '0;
        unique case (r_state)
            ST_DISPATCH: begin
                if (r_func == rmq_pkg::FUNC_APPEND && r_count < CNT_W'(MAX_ITEMS)) begin
                    mem_we    = 1'b1;
                    mem_waddr = tbl_addr('0, r_count[IDX_W-1:0]);
                    mem_wdata = {r_value, r_value};
                end
                mem_raddr = tbl_addr(q_lv, q_lo_ext[IDX_W-1:0]);
            end
            ST_APPEND: begin
                mem_we    = r_rd_vld;
                mem_waddr = tbl_addr(r_rd_lv, r_rd_j);
                mem_raddr = tbl_addr(ap_rd_lvc[LV_W-1:0], ap_j_ext[IDX_W-1:0]);
            end
            ST_QHI: begin
                mem_raddr = tbl_addr(r_q_lv, q_hi_ext[IDX_W-1:0]);
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    rmq_table #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W),
        .DATA_W (2 * VALUE_BITS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    rmq_minmax #(
        .VALUE_BITS (VALUE_BITS)
    ) u_minmax (
        .i_a_min (r_acc_min),
        .i_a_max (r_acc_max),
        .i_b_min (rd_min),
        .i_b_max (rd_max),
        .o_min   (u_min),
        .o_max   (u_max)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_count   <= '0;
            r_lv      <= '0;
            r_rd_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (r_out_vld && o_rsp.ready) begin
                r_out_vld <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (i_req.valid) begin
                        r_func  <= i_req.func;
                        r_value <= i_req.value;
                        r_begin <= i_req.range_begin;
                        r_end   <= i_req.range_end;
                        r_state <= ST_DISPATCH;
                    end
                end
                ST_DISPATCH: begin
                    r_res_min    <= '0;
                    r_res_max    <= '0;
                    r_res_status <= rmq_pkg::STATUS_OK;
                    r_state      <= ST_DONE;
                    unique case (r_func)
                        rmq_pkg::FUNC_CLEAR: begin
                            r_count <= '0;
                        end
                        rmq_pkg::FUNC_APPEND: begin
                            if (r_count >= CNT_W'(MAX_ITEMS)) begin
                                r_res_status <= rmq_pkg::STATUS_FULL;
                            end else begin
                                r_acc_min <= r_value;
                                r_acc_max <= r_value;
                                r_lv      <= LVC_W'(1);
                                r_state   <= ST_APPEND;
                            end
                        end
                        rmq_pkg::FUNC_QUERY: begin
                            if (q_bad) begin
                                r_res_status <= rmq_pkg::STATUS_RANGE;
                            end else begin
                                r_q_lv  <= q_lv;
                                r_state <= ST_QHI;
                            end
                        end
                        default: begin
                            r_res_status <= rmq_pkg::STATUS_OK;
                        end
                    endcase
                end
                ST_APPEND: begin
                    if (ap_issue) begin
                        r_lv    <= r_lv + LVC_W'(1);
                        r_rd_lv <= r_lv[LV_W-1:0];
                        r_rd_j  <= ap_j_ext[IDX_W-1:0];
                    end
                    r_rd_vld <= ap_issue;
                    if (r_rd_vld) begin
                        r_acc_min <= u_min;
                        r_acc_max <= u_max;
                    end
                    if (ap_done) begin
                        r_count <= r_count + CNT_W'(1);
                        r_state <= ST_DONE;
                    end
                end
                ST_QHI: begin
                    r_acc_min <= rd_min;
                    r_acc_max <= rd_max;
                    r_state   <= ST_QCOMB;
                end
                ST_QCOMB: begin
                    r_res_min <= u_min;
                    r_res_max <= u_max;
                    r_state   <= ST_DONE;
                end
                ST_DONE: begin
                    if (!r_out_vld || o_rsp.ready) begin
                        r_out_min    <= r_res_min;
                        r_out_max    <= r_res_max;
                        r_out_status <= r_res_status;
                        r_out_vld    <= 1'b1;
                        r_state      <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign i_req.ready     = (r_state == ST_IDLE);
    assign o_rsp.valid     = r_out_vld;
    assign o_rsp.range_min = r_out_min;
    assign o_rsp.range_max = r_out_max;
    assign o_rsp.status    = r_out_status;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_ITEMS))
        else $error("Element count exceeds the store depth.");

    a_rd_vld_append: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_vld |-> (r_state == ST_APPEND))
        else $error("Level read pending outside an append.");

    a_no_write_query: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_QHI || r_state == ST_QCOMB) |-> !mem_we)
        else $error("Table written during a query.");

    a_append_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_APPEND && ap_done) |=> (r_count == $past(r_count) + CNT_W'(1)))
        else $error("Append did not advance the element count by one.");

    a_min_le_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid |-> (o_rsp.range_min <= o_rsp.range_max))
        else $error("Response minimum exceeds maximum.");

endmodule
